// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl datapath
// expects signals clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CMSN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CMSN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/cmsn_pkg.sv -----
// types, constants and codes of the cost matrix neighbor unit
// no dependencies
package cmsn_pkg;

    localparam int MAX_NODES  = 64;
    localparam int NODE_BITS  = 6;
    localparam int COUNT_BITS = 7;
    localparam int COST_BITS  = 32;
    localparam int KEY_BITS   = 32;
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int TABLE_DEPTH = MAX_NODES * MAX_NODES;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_SET    = 3'd1,
        K_REMOVE = 3'd2,
        K_READ   = 3'd3,
        K_NEIGH  = 3'd4,
        K_DEPOT  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        RS_OK,
        RS_DUP,
        RS_UNKNOWN,
        RS_MISS,
        RS_FULL,
        RS_EMPTY,
        RS_NEW,
        RS_READ,
        RS_PEND_MORE,
        RS_PEND_LAST
    } res_sel_t;

    typedef struct packed {
        kind_t                       kind;
        logic [KEY_BITS-1:0]         name_key;
        logic [NODE_BITS-1:0]        from_node;
        logic [NODE_BITS-1:0]        to_node;
        logic signed [COST_BITS-1:0] weight;
    } in_item_t;

    typedef struct packed {
        status_t                     status;
        logic [NODE_BITS-1:0]        node;
        logic signed [COST_BITS-1:0] cost;
        logic                        last;
    } out_item_t;

    typedef struct packed {
        logic     load_item;
        logic     scan_start;
        logic     rd_scan;
        logic     rd_edge;
        logic     cap_edge;
        logic     pass_end;
        logic     clr_start;
        logic     wr_clr;
        logic     wr_edge;
        logic     wr_diag;
        logic     emit;
        res_sel_t sel;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  known;
        logic  from_ok;
        logic  from_eq_to;
        logic  count_zero;
        logic  count_full;
        logic  scan_last;
        logic  match;
        logic  found;
        logic  pend_valid;
        logic  edge_present;
        logic  clr_last;
        logic  out_free;
    } sts_t;

endpackage

// ----- rtl/cost_matrix_sorted_neighbors_unit.sv -----
// top level of the cost matrix unit with sorted neighbor listing
// depends on cmsn_pkg, cmsn_ctrl, cmsn_datapath and cmsn_ram
//
// square table of directed costs between up to 64 nodes, node 0 being the
// depot. one item inserts a node, sets, removes or reads a cost, lists a
// node's neighbors or lists the depot row. items are taken one at a time:
// in_ready is high only while the unit is idle. an insert scans the
// stored keys (one per cycle), then, unless the key is a duplicate or the
// table is full, clears the new row and column through the single write
// port of the cost memory. a list runs one selection pass over the row
// per entry found plus one closing pass, each pass reading every stored
// node. every result leaves through an output register, so a stalled
// consumer only holds the unit when a second result is ready. no clearing
// pass is needed after reset: a node's row and column are wiped when it is
// inserted.
module cost_matrix_sorted_neighbors_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cmsn_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output cmsn_pkg::out_item_t out_item
);
    import cmsn_pkg::*;

    // command and status between controller and datapath
    cmd_t cmd;
    sts_t sts;

    cmsn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cmsn_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ----- rtl/cmsn_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies
module cmsn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/cmsn_datapath.sv -----
// datapath: item registers, cost and key memories, scan compare, output register
// depends on cmsn_pkg, cmsn_ram and assert_macros.svh
`include "assert_macros.svh"

module cmsn_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  cmsn_pkg::cmd_t     cmd,
    output cmsn_pkg::sts_t     sts,
    input  cmsn_pkg::in_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cmsn_pkg::out_item_t out_item
);
    import cmsn_pkg::*;

    kind_t                 kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [NODE_BITS-1:0]  from_reg, to_reg;
    logic [COST_BITS-1:0]  weight_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [NODE_BITS-1:0]  idx_reg, ev_idx_reg;
    logic                  ev_valid_reg;
    logic                  found_reg, first_reg, match_reg, pend_valid_reg;
    logic [COST_BITS-1:0]  best_cost_reg, low_cost_reg, pend_cost_reg, rd_cost_reg;
    logic [KEY_BITS-1:0]   best_tb_reg, low_tb_reg;
    logic [NODE_BITS-1:0]  best_idx_reg, pend_idx_reg, match_idx_reg;
    logic [COUNT_BITS-1:0] clr_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    logic [NODE_BITS-1:0]  count6, row, wr_row, wr_col, new_idx;
    logic                  cost_we;
    logic [ADDR_BITS-1:0]  cost_waddr, cost_raddr;
    logic [COST_BITS:0]    cost_wdata, cost_rdata;
    logic [KEY_BITS-1:0]   key_rdata;
    logic [COST_BITS-1:0]  cand_cost;
    logic                  cand_present, eligible, gt_low, lt_best, out_free;
    logic [KEY_BITS-1:0]   cand_tb;
    out_item_t             res;

    assign count6   = count_reg[NODE_BITS-1:0];
    assign new_idx  = NODE_BITS'(count_reg - COUNT_BITS'(1));
    assign row      = (kind_reg == K_DEPOT) ? '0 : from_reg;
    assign out_free = !out_valid_reg || out_ready;

    // memory write select: edge update, row/column clear, diagonal
    always_comb
    begin
        wr_row = from_reg;
        wr_col = to_reg;
        cost_wdata = {(kind_reg == K_SET), weight_reg};
        if (cmd.wr_clr)
        begin
            wr_row = clr_reg[NODE_BITS] ? clr_reg[NODE_BITS-1:0] : count6;
            wr_col = clr_reg[NODE_BITS] ? count6 : clr_reg[NODE_BITS-1:0];
            cost_wdata = '0;
        end
        else if (cmd.wr_diag)
        begin
            wr_row = count6;
            wr_col = count6;
            cost_wdata = {1'b1, {COST_BITS{1'b0}}};
        end
    end

    assign cost_we    = cmd.wr_edge || cmd.wr_clr || cmd.wr_diag;
    assign cost_waddr = {wr_row, wr_col};
    assign cost_raddr = cmd.rd_edge ? {from_reg, to_reg} : {row, idx_reg};

    cmsn_ram #(.WIDTH(COST_BITS + 1), .DEPTH(TABLE_DEPTH)) u_cost_ram (
        .clk     (clk),
        .wr_en   (cost_we),
        .wr_addr (cost_waddr),
        .wr_data (cost_wdata),
        .rd_en   (cmd.rd_scan || cmd.rd_edge),
        .rd_addr (cost_raddr),
        .rd_data (cost_rdata)
    );

    cmsn_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_NODES)) u_key_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_diag),
        .wr_addr (count6),
        .wr_data (key_reg),
        .rd_en   (cmd.rd_scan),
        .rd_addr (idx_reg),
        .rd_data (key_rdata)
    );

    // candidate compare against lower bound and current best
    assign cand_cost    = cost_rdata[COST_BITS-1:0];
    assign cand_present = cost_rdata[COST_BITS];
    assign cand_tb      = (kind_reg == K_DEPOT) ? KEY_BITS'(ev_idx_reg) : key_rdata;
    assign eligible     = cand_present && (ev_idx_reg != row) && (ev_idx_reg != '0);
    assign gt_low  = first_reg
                  || ($signed(cand_cost) > $signed(low_cost_reg))
                  || ((cand_cost == low_cost_reg) && (cand_tb > low_tb_reg));
    assign lt_best = !found_reg
                  || ($signed(cand_cost) < $signed(best_cost_reg))
                  || ((cand_cost == best_cost_reg) && (cand_tb < best_tb_reg));

    always_comb
    begin
        res = '{status: ST_OK, node: '0, cost: '0, last: 1'b1};
        case (cmd.sel)
            RS_DUP:
            begin
                res.status = ST_DUP;
                res.node   = match_idx_reg;
            end
            RS_UNKNOWN: res.status = ST_UNKNOWN;
            RS_MISS:    res.status = ST_MISSING;
            RS_FULL:    res.status = ST_FULL;
            RS_EMPTY:   res.status = ST_EMPTY;
            RS_NEW:     res.node   = new_idx;
            RS_READ:
            begin
                res.node = to_reg;
                res.cost = rd_cost_reg;
            end
            RS_PEND_MORE:
            begin
                res.node = pend_idx_reg;
                res.cost = pend_cost_reg;
                res.last = 1'b0;
            end
            RS_PEND_LAST:
            begin
                res.node = pend_idx_reg;
                res.cost = pend_cost_reg;
            end
            default: res.status = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            match_reg     <= 1'b0;
            first_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= cmd.rd_scan;
            if (cmd.wr_diag)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (cmd.load_item)
            begin
                first_reg      <= 1'b1;
                pend_valid_reg <= (in_item.kind == K_DEPOT);
            end
            if (cmd.scan_start)
            begin
                found_reg <= 1'b0;
                match_reg <= 1'b0;
            end
            else if (ev_valid_reg)
            begin
                if (kind_reg == K_INSERT)
                begin
                    if (key_rdata == key_reg)
                    begin
                        match_reg <= 1'b1;
                    end
                end
                else if (eligible && gt_low && lt_best)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.pass_end && found_reg)
            begin
                first_reg      <= 1'b0;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg      <= in_item.kind;
            key_reg       <= in_item.name_key;
            from_reg      <= in_item.from_node;
            to_reg        <= in_item.to_node;
            weight_reg    <= in_item.weight;
            pend_idx_reg  <= '0;
            pend_cost_reg <= '0;
        end
        if (cmd.scan_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.rd_scan)
        begin
            idx_reg <= idx_reg + NODE_BITS'(1);
        end
        ev_idx_reg <= idx_reg;
        if (ev_valid_reg && !cmd.scan_start)
        begin
            if (kind_reg == K_INSERT)
            begin
                if (key_rdata == key_reg)
                begin
                    match_idx_reg <= ev_idx_reg;
                end
            end
            else if (eligible && gt_low && lt_best)
            begin
                best_cost_reg <= cand_cost;
                best_tb_reg   <= cand_tb;
                best_idx_reg  <= ev_idx_reg;
            end
        end
        if (cmd.pass_end && found_reg)
        begin
            low_cost_reg  <= best_cost_reg;
            low_tb_reg    <= best_tb_reg;
            pend_cost_reg <= best_cost_reg;
            pend_idx_reg  <= best_idx_reg;
        end
        if (cmd.cap_edge)
        begin
            rd_cost_reg <= cand_cost;
        end
        if (cmd.clr_start)
        begin
            clr_reg <= '0;
        end
        else if (cmd.wr_clr)
        begin
            clr_reg <= clr_reg + COUNT_BITS'(1);
        end
        if (cmd.emit)
        begin
            out_item_reg <= res;
        end
    end

    // a key match only holds when the matched slot was really scanned
    assign sts.kind         = kind_reg;
    assign sts.known        = ({1'b0, from_reg} < count_reg) && ({1'b0, to_reg} < count_reg);
    assign sts.from_ok      = {1'b0, from_reg} < count_reg;
    assign sts.from_eq_to   = from_reg == to_reg;
    assign sts.count_zero   = count_reg == '0;
    assign sts.count_full   = count_reg == COUNT_BITS'(MAX_NODES);
    assign sts.scan_last    = ({1'b0, idx_reg} + COUNT_BITS'(1)) == count_reg;
    assign sts.match        = match_reg;
    assign sts.found        = found_reg;
    assign sts.pend_valid   = pend_valid_reg;
    assign sts.edge_present = cand_present;
    assign sts.clr_last     = &clr_reg;
    assign sts.out_free     = out_free;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `CMSN_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_BITS'(MAX_NODES))
    `CMSN_ASSERT_IMP(a_emit_free, cmd.emit, out_free)
    `CMSN_ASSERT_NXT(a_count_step, cmd.wr_diag, count_reg == $past(count_reg) + COUNT_BITS'(1))
    `CMSN_ASSERT_IMP(a_no_insert_full, cmd.wr_diag, count_reg < COUNT_BITS'(MAX_NODES))

endmodule

// ----- rtl/cmsn_ctrl.sv -----
// controller state machine sequencing scans, clears and result emission
// depends on cmsn_pkg
module cmsn_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cmsn_pkg::sts_t sts,
    output cmsn_pkg::cmd_t cmd
);
    import cmsn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_TAIL,
        S_INS_DEC,
        S_CLR,
        S_DIAG,
        S_RD_WAIT,
        S_PASS,
        S_PEND,
        S_EMIT
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t sel_reg, sel_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_EMIT;
                sel_next   = RS_OK;
                unique case (sts.kind) inside
                    K_INSERT:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = sts.count_zero ? S_INS_DEC : S_SCAN;
                    end
                    K_SET, K_REMOVE:
                    begin
                        if (!sts.known)
                        begin
                            sel_next = RS_UNKNOWN;
                        end
                        else if (sts.kind == K_REMOVE || !sts.from_eq_to)
                        begin
                            cmd.wr_edge = 1'b1;
                        end
                    end
                    K_READ:
                    begin
                        if (!sts.known)
                        begin
                            sel_next = RS_UNKNOWN;
                        end
                        else
                        begin
                            cmd.rd_edge = 1'b1;
                            state_next  = S_RD_WAIT;
                        end
                    end
                    K_NEIGH:
                    begin
                        if (!sts.from_ok)
                        begin
                            sel_next = RS_UNKNOWN;
                        end
                        else
                        begin
                            state_next = S_PASS;
                        end
                    end
                    K_DEPOT:
                    begin
                        if (sts.count_zero)
                        begin
                            sel_next = RS_EMPTY;
                        end
                        else
                        begin
                            state_next = S_PASS;
                        end
                    end
                    default: sel_next = RS_OK;
                endcase
            end
            S_PASS:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.rd_scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = (sts.kind == K_INSERT) ? S_INS_DEC : S_PEND;
            end
            S_INS_DEC:
            begin
                state_next = S_EMIT;
                if (sts.match)
                begin
                    sel_next = RS_DUP;
                end
                else if (sts.count_full)
                begin
                    sel_next = RS_FULL;
                end
                else
                begin
                    cmd.clr_start = 1'b1;
                    state_next    = S_CLR;
                end
            end
            S_CLR:
            begin
                cmd.wr_clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_DIAG;
                end
            end
            S_DIAG:
            begin
                cmd.wr_diag = 1'b1;
                sel_next    = RS_NEW;
                state_next  = S_EMIT;
            end
            S_RD_WAIT:
            begin
                cmd.cap_edge = 1'b1;
                sel_next     = sts.edge_present ? RS_READ : RS_MISS;
                state_next   = S_EMIT;
            end
            S_PEND:
            begin
                // a found entry pushes the held one out; none found closes the list
                if (sts.found)
                begin
                    if (!sts.pend_valid || sts.out_free)
                    begin
                        cmd.pass_end = 1'b1;
                        cmd.emit     = sts.pend_valid;
                        cmd.sel      = RS_PEND_MORE;
                        state_next   = S_PASS;
                    end
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = sts.pend_valid ? RS_PEND_LAST : RS_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= RS_OK;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ----- dv/cost_matrix_sorted_neighbors_unit_tb.sv -----
// testbench of the cost matrix unit: a directed table, then random items, scored
// against typed results or a behavioral predictor of table, keys, sorted listing
// depends on cmsn_pkg and cost_matrix_sorted_neighbors_unit
module cost_matrix_sorted_neighbors_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmsn_pkg::*;

    localparam int IDLE_LIMIT  = 5000;   // cycles with no item moving either way before giving up
    localparam int RAND_ITEMS  = 195;
    localparam int HOLD_CYCLES = 800;    // long receiver hold-off

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    cost_matrix_sorted_neighbors_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the block's table
    logic signed [COST_BITS-1:0] shadow_cost [MAX_NODES][MAX_NODES];
    bit                          shadow_here [MAX_NODES][MAX_NODES];
    logic [KEY_BITS-1:0]         shadow_key  [MAX_NODES];
    int                          shadow_count;

    out_item_t pending_results [$];
    int        err_cnt;
    int        results_seen;

    // directed table
    typedef struct {
        in_item_t  item;
        bit        typed;     // expected result typed in below
        out_item_t want;
    } dir_row_t;
    dir_row_t dir_rows [$];

    function automatic out_item_t mk_res(status_t st, int nd, logic signed [31:0] c, bit lst);
        out_item_t r;
        r.status = st;
        r.node   = nd[NODE_BITS-1:0];
        r.cost   = c;
        r.last   = lst;
        return r;
    endfunction

    // a precedes b in row r
    function automatic bit goes_first(int r, int a, int b, bit by_key);
        if (shadow_cost[r][a] != shadow_cost[r][b])
            return shadow_cost[r][a] < shadow_cost[r][b];
        if (by_key)
            return shadow_key[a] < shadow_key[b];
        return a < b;
    endfunction

    // sorted listing of a row into the result store
    task automatic list_row_results(int r, bit depot, ref out_item_t res [$]);
        int order [$];
        int j;
        int k;
        k = 0;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (i == r || i == 0 || !shadow_here[r][i])
                continue;
            j = order.size();
            order.insert(order.size(), i);
            while (j > 0 && goes_first(r, i, order[j-1], !depot))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        if (depot)
        begin
            res.insert(res.size(), mk_res(ST_OK, 0, 0, order.size() == 0));
            k = 1;
        end
        else if (order.size() == 0)
        begin
            res.insert(res.size(), mk_res(ST_EMPTY, 0, 0, 1'b1));
            return;
        end
        for (int i = 0; i < order.size() && k < 64; i++)
        begin
            res.insert(res.size(), mk_res(ST_OK, order[i], shadow_cost[r][order[i]],
                                          (i + 1 == order.size()) || (k + 1 == 64)));
            k++;
        end
    endtask

    // apply one item to the shadow table, return the results it causes
    task automatic predict_table_op(in_item_t it, ref out_item_t res [$]);
        int  f;
        int  t;
        bit  known;
        bit  dup;
        f = it.from_node;
        t = it.to_node;
        known = (f < shadow_count) && (t < shadow_count);
        res.delete();
        case (it.kind)
            K_INSERT:
            begin
                dup = 1'b0;
                for (int i = 0; i < shadow_count; i++)
                    if (!dup && shadow_key[i] == it.name_key)
                    begin
                        res.insert(res.size(), mk_res(ST_DUP, i, 0, 1'b1));
                        dup = 1'b1;
                    end
                if (!dup)
                begin
                    if (shadow_count >= MAX_NODES)
                        res.insert(res.size(), mk_res(ST_FULL, 0, 0, 1'b1));
                    else
                    begin
                        for (int i = 0; i < MAX_NODES; i++)
                        begin
                            shadow_here[shadow_count][i] = 1'b0;
                            shadow_here[i][shadow_count] = 1'b0;
                        end
                        shadow_key[shadow_count] = it.name_key;
                        shadow_cost[shadow_count][shadow_count] = 0;
                        shadow_here[shadow_count][shadow_count] = 1'b1;
                        res.insert(res.size(), mk_res(ST_OK, shadow_count, 0, 1'b1));
                        shadow_count++;
                    end
                end
            end
            K_SET:
            begin
                if (!known)
                    res.insert(res.size(), mk_res(ST_UNKNOWN, 0, 0, 1'b1));
                else
                begin
                    if (f != t)
                    begin
                        shadow_cost[f][t] = it.weight;
                        shadow_here[f][t] = 1'b1;
                    end
                    res.insert(res.size(), mk_res(ST_OK, 0, 0, 1'b1));
                end
            end
            K_REMOVE:
            begin
                if (!known)
                    res.insert(res.size(), mk_res(ST_UNKNOWN, 0, 0, 1'b1));
                else
                begin
                    shadow_here[f][t] = 1'b0;
                    res.insert(res.size(), mk_res(ST_OK, 0, 0, 1'b1));
                end
            end
            K_READ:
            begin
                if (!known)
                    res.insert(res.size(), mk_res(ST_UNKNOWN, 0, 0, 1'b1));
                else if (!shadow_here[f][t])
                    res.insert(res.size(), mk_res(ST_MISSING, 0, 0, 1'b1));
                else
                    res.insert(res.size(), mk_res(ST_OK, t, shadow_cost[f][t], 1'b1));
            end
            K_NEIGH:
            begin
                if (f >= shadow_count)
                    res.insert(res.size(), mk_res(ST_UNKNOWN, 0, 0, 1'b1));
                else
                    list_row_results(f, 1'b0, res);
            end
            K_DEPOT:
            begin
                if (shadow_count == 0)
                    res.insert(res.size(), mk_res(ST_EMPTY, 0, 0, 1'b1));
                else
                    list_row_results(0, 1'b1, res);
            end
            default:
                res.insert(res.size(), mk_res(ST_OK, 0, 0, 1'b1));
        endcase
    endtask

    task automatic add_row(logic [2:0] k, logic [31:0] key, int f, int t,
                           logic signed [31:0] w, bit typed,
                           status_t st = ST_OK, int nd = 0, logic signed [31:0] c = 0);
        dir_row_t row;
        row.item.kind      = kind_t'(k);
        row.item.name_key  = key;
        row.item.from_node = f[NODE_BITS-1:0];
        row.item.to_node   = t[NODE_BITS-1:0];
        row.item.weight    = w;
        row.typed          = typed;
        row.want           = mk_res(st, nd, c, 1'b1);
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // index mostly among the present nodes, one past them, sometimes anywhere
    function automatic int pick_node();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, (shadow_count > 63) ? 63 : shadow_count);
    endfunction

    function automatic in_item_t random_item(int n);
        in_item_t it;
        int       roll;
        it.name_key  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 40);
        it.from_node = NODE_BITS'(pick_node());
        it.to_node   = NODE_BITS'(pick_node());
        // narrow weights force ties in the listing
        it.weight    = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 6) - 3;
        roll = $urandom_range(0, 99);
        if (n >= 100 && n < 170)
        begin
            // fill phase: fresh keys until the table is full
            it.kind = K_INSERT;
            it.name_key = $urandom();
        end
        else if (roll < 20) it.kind = K_INSERT;
        else if (roll < 50) it.kind = K_SET;
        else if (roll < 60) it.kind = K_REMOVE;
        else if (roll < 76) it.kind = K_READ;
        else if (roll < 88) it.kind = K_NEIGH;
        else if (roll < 97) it.kind = K_DEPOT;
        else                it.kind = kind_t'($urandom_range(6, 7));
        return it;
    endfunction

    // idle draw: a random idle gap, none within bursts of back-to-back items
    function automatic int idle_draw(int n);
        if ((n % 40) < 12)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // hand one item to the block and queue what it should produce
    task automatic send_item(in_item_t it, int n, bit typed, out_item_t want);
        out_item_t res [$];
        int        gap;
        gap = idle_draw(n);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        predict_table_op(it, res);
        if (typed)
            pending_results.insert(pending_results.size(), want);
        else
            foreach (res[i])
                pending_results.insert(pending_results.size(), res[i]);
    endtask

    // sender
    initial
    begin
        out_item_t none;
        none = '0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        err_cnt   = 0;
        shadow_count = 0;
        for (int i = 0; i < MAX_NODES; i++)
            for (int j = 0; j < MAX_NODES; j++)
                shadow_here[i][j] = 1'b0;

        // empty table: unknown indices, empty depot list, unused kinds
        add_row(K_READ,   0, 0, 0, 0, 1, ST_UNKNOWN);
        add_row(K_NEIGH,  0, 0, 0, 0, 1, ST_UNKNOWN);
        add_row(K_DEPOT,  0, 0, 0, 0, 1, ST_EMPTY);
        add_row(3'd6, 32'hFFFF_FFFF, 63, 63, -1, 1, ST_OK);
        add_row(3'd7, 0, 0, 0, 0, 1, ST_OK);
        // inserts, duplicate key
        add_row(K_INSERT, 32'h0000_0000, 0, 0, 0, 1, ST_OK, 0);
        add_row(K_INSERT, 32'hFFFF_FFFF, 0, 0, 0, 1, ST_OK, 1);
        add_row(K_INSERT, 32'h0000_0000, 0, 0, 0, 1, ST_DUP, 0);
        add_row(K_INSERT, 32'h8000_0000, 0, 0, 0, 1, ST_OK, 2);
        // extreme weights, read back
        add_row(K_SET,    0, 0, 1, 32'sh8000_0000, 1, ST_OK);
        add_row(K_SET,    0, 1, 0, 32'sh7FFF_FFFF, 1, ST_OK);
        add_row(K_READ,   0, 0, 1, 0, 1, ST_OK, 1, 32'sh8000_0000);
        add_row(K_READ,   0, 1, 0, 0, 1, ST_OK, 0, 32'sh7FFF_FFFF);
        // set onto itself changes nothing, remove clears the diagonal
        add_row(K_SET,    0, 1, 1, 77, 1, ST_OK);
        add_row(K_READ,   0, 1, 1, 0, 1, ST_OK, 1, 0);
        add_row(K_REMOVE, 0, 1, 1, 0, 1, ST_OK);
        add_row(K_READ,   0, 1, 1, 0, 1, ST_MISSING);
        add_row(K_SET,    0, 0, 63, 5, 1, ST_UNKNOWN);
        add_row(K_REMOVE, 0, 63, 0, 0, 1, ST_UNKNOWN);
        // row 1 holds only the depot: empty neighbor list
        add_row(K_NEIGH,  0, 1, 0, 0, 1, ST_EMPTY);
        // ties: equal costs ordered by key in neighbor lists, by index from the depot
        add_row(K_SET,    0, 2, 1, 9, 0);
        add_row(K_INSERT, 32'h0000_0005, 0, 0, 0, 0);
        add_row(K_SET,    0, 2, 3, 9, 0);
        add_row(K_NEIGH,  0, 2, 0, 0, 0);
        add_row(K_SET,    0, 0, 2, -4, 0);
        add_row(K_SET,    0, 0, 3, 32'sh8000_0000, 0);
        add_row(K_DEPOT,  0, 0, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, i, dir_rows[i].typed, dir_rows[i].want);
        for (int n = 0; n < RAND_ITEMS; n++)
            send_item(random_item(n), n, 1'b0, none);
        in_valid  <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (300) @(posedge clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        int        gap;
        out_item_t want;
        out_ready    = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            gap = (results_seen == 40) ? HOLD_CYCLES : idle_draw(results_seen);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, got %p", $time, out_item);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             out_item.status);
                    err_cnt++;
                end
                if (out_item.node !== want.node)
                begin
                    $display("%0t: node expected %0d actual %0d", $time, want.node,
                             out_item.node);
                    err_cnt++;
                end
                if (out_item.cost !== want.cost)
                begin
                    $display("%0t: cost expected %0d actual %0d", $time, want.cost,
                             out_item.cost);
                    err_cnt++;
                end
                if (out_item.last !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last,
                             out_item.last);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving either way
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("%0t: no progress, %0d results outstanding", $time,
                         pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
